@@ hdl/modular_exponentiation_core_defines.svh @@
// assertion macros for the modular exponentiation core
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/modexp_pkg.sv @@
// package with types and constants of the modular exponentiation core
`default_nettype none

package modexp_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int FIELD_WIDTH   = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_DBL,
    ST_ADD,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ hdl/modular_exponentiation_core.sv @@
// modular exponentiation core: right-to-left binary method, bit-serial modular multiply
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-------------------------------------
//  in_     | in  | in_tvalid / in_tready      | in_tdata: base_value, exponent_value
//  out_    | out | out_tvalid / out_tready    | out_tdata: power_residue
//  cfg_    | in  | cfg_wr_en                  | cfg_wr_data: modulus
//
// one transaction at a time: the base is first reduced modulo the modulus, then each
// exponent bit takes a check step and, per multiplier bit, one double step and one add
// step, square and multiply side by side.
// a modulus of 0 or 1 skips all of it and gives a zero result.
// reset loads the modulus with 1; a finished result waits in the output register,
// and the next result waits in the finish state until the previous one is taken.
`default_nettype none

`include "modular_exponentiation_core_defines.svh"

module modular_exponentiation_core #(
  parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,     // [31:0] base_value, [63:32] exponent_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,    // [31:0] power_residue
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data   // modulus
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);
  localparam int FW = modexp_pkg::FIELD_WIDTH;
  localparam int XW = (W > FW) ? W : FW;

  // x + y mod m, with x < m and y < m
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    logic [W:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, m};
    add_mod = (s >= {1'b0, m}) ? d[W-1:0] : s[W-1:0];
  endfunction

  modexp_pkg::state_t st_r, st_nxt;
  logic [FW-1:0] mod_r, mod_nxt;
  logic [W-1:0]  base_r, base_nxt;
  logic [W-1:0]  exp_r, exp_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic [W-1:0]  bsh_r, bsh_nxt;
  logic [W-1:0]  accr_r, accr_nxt;
  logic [W-1:0]  accb_r, accb_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [FW-1:0] out_tdata_r, out_tdata_nxt;

  logic [XW-1:0] mod_ext, base_ext, exp_ext, res_ext;
  logic [W-1:0]  m_w, base_w, exp_w;
  logic          m_le1;
  logic [W:0]    rem_sh, rem_sub;
  logic [W-1:0]  rem_new;
  logic [W-1:0]  dbl_r, dbl_b, add_r, add_b;
  logic          last_bit;

  assign mod_ext  = XW'(mod_r);
  assign base_ext = XW'(in_tdata[FW-1:0]);
  assign exp_ext  = XW'(in_tdata[2*FW-1:FW]);
  assign res_ext  = XW'(res_r);
  assign m_w      = mod_ext[W-1:0];
  assign base_w   = base_ext[W-1:0];
  assign exp_w    = exp_ext[W-1:0];
  assign m_le1    = (m_w <= W'(1));

  // restoring remainder step: shift in the next base bit, subtract the modulus if it fits
  assign rem_sh  = {base_r, bsh_r[W-1]};
  assign rem_sub = rem_sh - {1'b0, m_w};
  assign rem_new = (rem_sh >= {1'b0, m_w}) ? rem_sub[W-1:0] : rem_sh[W-1:0];

  assign dbl_r = add_mod(accr_r, accr_r, m_w);
  assign dbl_b = add_mod(accb_r, accb_r, m_w);
  assign add_r = bsh_r[W-1] ? add_mod(accr_r, res_r, m_w) : accr_r;
  assign add_b = bsh_r[W-1] ? add_mod(accb_r, base_r, m_w) : accb_r;

  assign last_bit = (cnt_r == CW'(W - 1));

  assign in_tready  = (st_r == modexp_pkg::ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    st_nxt         = st_r;
    mod_nxt        = mod_r;
    base_nxt       = base_r;
    exp_nxt        = exp_r;
    res_nxt        = res_r;
    bsh_nxt        = bsh_r;
    accr_nxt       = accr_r;
    accb_nxt       = accb_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    if (cfg_wr_en) begin
      mod_nxt = cfg_wr_data;
    end

    unique case (st_r)
      modexp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cnt_nxt  = '0;
          base_nxt = '0;
          bsh_nxt  = base_w;
          res_nxt  = W'(1);
          exp_nxt  = exp_w;
          st_nxt   = modexp_pkg::ST_REDUCE;
          if (m_le1) begin
            res_nxt = '0;
            exp_nxt = '0;
            st_nxt  = modexp_pkg::ST_CHECK;
          end
        end
      end
      modexp_pkg::ST_REDUCE: begin
        base_nxt = rem_new;
        bsh_nxt  = bsh_r << 1;
        cnt_nxt  = cnt_r + CW'(1);
        if (last_bit) begin
          st_nxt = modexp_pkg::ST_CHECK;
        end
      end
      modexp_pkg::ST_CHECK: begin
        if (exp_r == '0) begin
          st_nxt = modexp_pkg::ST_FINISH;
        end else begin
          bsh_nxt  = base_r;
          accr_nxt = '0;
          accb_nxt = '0;
          cnt_nxt  = '0;
          st_nxt   = modexp_pkg::ST_DBL;
        end
      end
      modexp_pkg::ST_DBL: begin
        accr_nxt = dbl_r;
        accb_nxt = dbl_b;
        st_nxt   = modexp_pkg::ST_ADD;
      end
      modexp_pkg::ST_ADD: begin
        accr_nxt = add_r;
        accb_nxt = add_b;
        bsh_nxt  = bsh_r << 1;
        cnt_nxt  = cnt_r + CW'(1);
        st_nxt   = modexp_pkg::ST_DBL;
        if (last_bit) begin
          // commit: multiply only where the exponent bit is set, square always
          res_nxt  = exp_r[0] ? add_r : res_r;
          base_nxt = add_b;
          exp_nxt  = exp_r >> 1;
          st_nxt   = modexp_pkg::ST_CHECK;
        end
      end
      modexp_pkg::ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = res_ext[FW-1:0];
          st_nxt         = modexp_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = modexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= modexp_pkg::ST_IDLE;
      mod_r        <= FW'(1);
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      mod_r        <= mod_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    exp_r       <= exp_nxt;
    res_r       <= res_nxt;
    bsh_r       <= bsh_nxt;
    accr_r      <= accr_nxt;
    accb_r      <= accb_nxt;
    cnt_r       <= cnt_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  `MEC_ASSERT_NOW(a_base_reduced,
    (st_r == modexp_pkg::ST_DBL || st_r == modexp_pkg::ST_ADD),
    (base_r < m_w) && (res_r < m_w),
    "base or running result not below modulus")

  `MEC_ASSERT_NOW(a_acc_reduced,
    (st_r == modexp_pkg::ST_DBL || st_r == modexp_pkg::ST_ADD),
    (accr_r < m_w) && (accb_r < m_w),
    "multiply accumulator not below modulus")

  `MEC_ASSERT_NEXT(a_small_modulus,
    (in_tvalid && in_tready && m_le1),
    (st_r == modexp_pkg::ST_CHECK) && (res_r == '0) && (exp_r == '0),
    "modulus of one or zero must give a zero result")

  `MEC_ASSERT_NEXT(a_result_loaded,
    (st_r == modexp_pkg::ST_FINISH && (!out_tvalid_r || out_tready)),
    out_tvalid_r && (st_r == modexp_pkg::ST_IDLE),
    "finished result not moved to the output register")

endmodule

`default_nettype wire
